// File: sv/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

   localparam int TABLE_SIZE_DEF = 32;

   localparam int OP_W    = 2;
   localparam int KEY_W   = 31;
   localparam int VAL_W   = 32;
   localparam int STS_W   = 2;
   localparam int SLOT_W  = 2;
   localparam int ENTRY_W = SLOT_W + KEY_W + VAL_W;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 40;

   // remainder unit: reciprocal multiply, back multiply, one correcting subtract
   localparam int MOD_STEPS = 3;
   localparam int MCNT_W    = $clog2(MOD_STEPS);

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   localparam logic [SLOT_W-1:0] SLOT_EMPTY   = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_USED    = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_DELETED = 2'd2;

   localparam logic [STS_W-1:0] RES_OK      = 2'd0;
   localparam logic [STS_W-1:0] RES_MISSING = 2'd1;
   localparam logic [STS_W-1:0] RES_FULL    = 2'd2;

   typedef struct packed {
      logic clr_write;
      logic load_req;
      logic mod_step;
      logic probe_run;
      logic out_load;
   } lpht_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic mod_last;
      logic probe_done;
   } lpht_sts_type;

endpackage

// File: sv/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// lpht_ctrl
// Sequencer: clearing pass, key reduction, probe and result handshake.
// ----------------------------------------------------------------------------
module lpht_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output lpht_pkg::lpht_cmd_type cmd,
   input  lpht_pkg::lpht_sts_type sts
);

   import lpht_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_MOD    = 3'd2;
   localparam logic [2:0] S_PROBE  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.clr_write = (state_ff == S_CLEAR);
      cmd.load_req  = (state_ff == S_IDLE) && req_tvalid;
      cmd.mod_step  = (state_ff == S_MOD);
      cmd.probe_run = (state_ff == S_PROBE);
      // result waits until the output register is free
      cmd.out_load  = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_tready);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) state_in = S_MOD;
         end
         S_MOD: begin
            if (sts.mod_last) state_in = S_PROBE;
         end
         S_PROBE: begin
            if (sts.probe_done) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (cmd.out_load) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_tready) || cmd.out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: sv/lpht_dpath.sv
// ----------------------------------------------------------------------------
// lpht_dpath
// Slot store, key remainder unit, probe address walk and result registers.
// ----------------------------------------------------------------------------
module lpht_dpath #(
   parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lpht_pkg::lpht_cmd_type      cmd,
   output lpht_pkg::lpht_sts_type      sts,
   input  logic [lpht_pkg::OP_W-1:0]   req_op,
   input  logic [lpht_pkg::KEY_W-1:0]  req_key,
   input  logic [lpht_pkg::VAL_W-1:0]  req_value,
   output logic [lpht_pkg::STS_W-1:0]  rsp_status,
   output logic [lpht_pkg::VAL_W-1:0]  rsp_found_value
);

   import lpht_pkg::*;

   localparam int IW = $clog2(TABLE_SIZE);
   localparam int CW = $clog2(TABLE_SIZE + 1);
   localparam int PW = 2 * KEY_W;
   // quotient estimate from this reciprocal is at most one short
   localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / TABLE_SIZE);

   // request registers
   logic [OP_W-1:0]  op_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] val_ff;

   // clearing pass
   logic [IW-1:0] clr_addr_ff;

   // remainder unit
   logic [PW-1:0]     prod_ff;
   logic [KEY_W-1:0]  back_ff;
   logic [KEY_W-1:0]  diff;
   logic [KEY_W-1:0]  red;
   logic [IW-1:0]     rem_in;
   logic [MCNT_W-1:0] mod_cnt_ff;

   // probe walk
   logic [IW-1:0] addr_ff, rd_addr_ff;
   logic [CW-1:0] issue_cnt_ff;
   logic          rd_valid_ff, rd_last_ff;
   logic          issue;

   // slot store
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;
   logic [SLOT_W-1:0]  e_slot;
   logic [KEY_W-1:0]   e_key;
   logic [VAL_W-1:0]   e_val;

   // probe decision
   logic               done;
   logic               hit_wr;
   logic [ENTRY_W-1:0] hit_data;
   logic [STS_W-1:0]   done_status;
   logic [VAL_W-1:0]   done_value;

   logic [STS_W-1:0] res_status_ff, out_status_ff;
   logic [VAL_W-1:0] res_value_ff, out_value_ff;

   // key minus estimated multiple lies below twice the table size
   always_comb begin
      diff   = key_ff - back_ff;
      red    = (diff >= KEY_W'(TABLE_SIZE)) ? diff - KEY_W'(TABLE_SIZE) : diff;
      rem_in = red[IW-1:0];
   end

   assign sts.clr_last = (clr_addr_ff == IW'(TABLE_SIZE - 1));
   assign sts.mod_last = (mod_cnt_ff == MCNT_W'(MOD_STEPS - 1));

   assign issue = cmd.probe_run && (issue_cnt_ff != CW'(TABLE_SIZE));

   assign e_slot = rd_data[SLOT_W-1:0];
   assign e_key  = rd_data[SLOT_W +: KEY_W];
   assign e_val  = rd_data[SLOT_W+KEY_W +: VAL_W];

   always_comb begin
      done        = 1'b0;
      hit_wr      = 1'b0;
      hit_data    = {val_ff, key_ff, SLOT_USED};
      done_status = RES_MISSING;
      done_value  = '0;
      if (cmd.probe_run && rd_valid_ff) begin
         case (op_ff)
            OP_INSERT: begin
               if (e_slot != SLOT_USED) begin
                  done        = 1'b1;
                  hit_wr      = 1'b1;
                  done_status = RES_OK;
               end else if (rd_last_ff) begin
                  done        = 1'b1;
                  done_status = RES_FULL;
               end
            end
            OP_SEARCH, OP_DELETE: begin
               if (e_slot == SLOT_EMPTY) begin
                  done = 1'b1;
               end else if (e_slot == SLOT_USED && e_key == key_ff) begin
                  done        = 1'b1;
                  done_status = RES_OK;
                  done_value  = e_val;
                  hit_wr      = (op_ff == OP_DELETE);
                  hit_data    = {e_val, e_key, SLOT_DELETED};
               end else if (rd_last_ff) begin
                  done = 1'b1;
               end
            end
            default: begin
               done = 1'b1;
            end
         endcase
      end
   end

   assign sts.probe_done = done;

   always_comb begin
      if (cmd.clr_write) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = {{(ENTRY_W - SLOT_W){1'b0}}, SLOT_EMPTY};
      end else begin
         wr_en   = hit_wr;
         wr_addr = rd_addr_ff;
         wr_data = hit_data;
      end
   end

   lpht_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SIZE)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         mod_cnt_ff   <= '0;
         issue_cnt_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (cmd.clr_write) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (cmd.load_req) begin
            mod_cnt_ff <= '0;
         end else if (cmd.mod_step) begin
            mod_cnt_ff <= mod_cnt_ff + 1'b1;
         end
         if (cmd.mod_step && sts.mod_last) begin
            issue_cnt_ff <= '0;
         end else if (issue) begin
            issue_cnt_ff <= issue_cnt_ff + 1'b1;
         end
         rd_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_op;
         key_ff <= req_key;
         val_ff <= req_value;
      end
      // quotient estimate, then its multiple of the table size
      if (cmd.mod_step) begin
         prod_ff <= PW'(key_ff) * PW'(RECIP);
         back_ff <= prod_ff[PW-1 -: KEY_W] * KEY_W'(TABLE_SIZE);
      end
      if (cmd.mod_step && sts.mod_last) begin
         addr_ff <= rem_in;
      end else if (issue) begin
         addr_ff <= (addr_ff == IW'(TABLE_SIZE - 1)) ? '0 : addr_ff + 1'b1;
      end
      if (issue) begin
         rd_addr_ff <= addr_ff;
         rd_last_ff <= (issue_cnt_ff == CW'(TABLE_SIZE - 1));
      end
      if (done) begin
         res_status_ff <= done_status;
         res_value_ff  <= done_value;
      end
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_value_ff  <= res_value_ff;
      end
   end

   assign rsp_status      = out_status_ff;
   assign rsp_found_value = out_value_ff;

endmodule

// File: sv/linear_probe_hash_table.sv
// Path: from the accepting edge to rsp_tvalid a request passes the key remainder unit,
//   then one slot probe a cycle through the registered read, then the output register.
// Requests: one item at a time; a new one is taken only after the last result is loaded
//   into the result register; a result left waiting on rsp_tready holds back the next one.
// Reset: synchronous; afterwards a clearing pass empties
//   every slot while req_tready stays low.
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing key/data table with linear probing: insert, search, delete.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
   parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // op [1:0], key [32:2], value [64:33], zero fill above
   input  logic [lpht_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // status [1:0], found_value [33:2], zero fill above
   output logic [lpht_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   import lpht_pkg::*;

   lpht_cmd_type     cmd;
   lpht_sts_type     sts;
   logic [STS_W-1:0] rsp_status;
   logic [VAL_W-1:0] rsp_found_value;

   lpht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   lpht_dpath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_op          (req_tdata[OP_W-1:0]),
      .req_key         (req_tdata[OP_W +: KEY_W]),
      .req_value       (req_tdata[OP_W+KEY_W +: VAL_W]),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value)
   );

   assign rsp_tdata = RSP_TDATA_W'({rsp_found_value, rsp_status});

endmodule
